// File: src/rrbs_pkg.sv
`timescale 1ns / 1ps

package rrbs_pkg;

  localparam int NUM_REQ = 8;
  localparam int IDX_W   = 3;
  localparam int WORD_W  = 32;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [0:0]        cfg_idx_t;
  typedef logic [1:0]        op_t;

  localparam cfg_idx_t CFG_BASE = 1'b0;
  localparam cfg_idx_t CFG_MAX  = 1'b1;

  localparam op_t OP_RAISE   = 2'd0;
  localparam op_t OP_POLL    = 2'd1;
  localparam op_t OP_OUTCOME = 2'd2;

  typedef struct packed {
    op_t   operation;
    idx_t  request_index;
    word_t now_ms;
    logic  link_up;
    logic  success;
  } in_t;

  typedef struct packed {
    logic  dispatched;
    idx_t  dispatch_index;
    word_t scheduled_delay_ms;
  } out_t;

  // Operand set for the shared adder/subtractor
  typedef struct packed {
    word_t a;
    word_t b;
    logic  sub;
  } alu_req_t;

endpackage

// File: src/rrbs_addsub.sv
`timescale 1ns / 1ps

module rrbs_addsub (
  input  rrbs_pkg::alu_req_t req,
  output rrbs_pkg::word_t    sum,
  output logic               carry
);
  import rrbs_pkg::*;

  word_t operand_b;

  // Invert b and inject carry for subtraction; carry out high means a >= b
  assign operand_b = req.sub ? ~req.b : req.b;
  assign {carry, sum} = {1'b0, req.a} + {1'b0, operand_b} + (WORD_W + 1)'(req.sub);

endmodule

// File: src/round_robin_retry_backoff_scheduler_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data   (rrbs_pkg::in_t)
// out      output     out_valid / out_ready  out_data  (rrbs_pkg::out_t)
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// One transaction at a time; each gives exactly one result. Raise, ignored
// poll or outcome, spare code and success outcome go straight to the result;
// a poll scans one entry per cycle through the shared subtractor up to a hit
// or the last entry; a failure outcome runs delay compare, then retry time add.
// Reset (rst_n low, synchronous) clears all flags and pointers at once.
// in_ready drops while a transaction is in progress; a result waiting in
// the output register stalls the next transaction only at its own result.
module round_robin_retry_backoff_scheduler_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrbs_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrbs_pkg::out_t     out_data,
  input  logic               cfg_we,
  input  rrbs_pkg::cfg_idx_t cfg_index,
  input  rrbs_pkg::word_t    cfg_data
);
  import rrbs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_GROW = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam idx_t LAST_CNT = IDX_W'(NUM_REQ - 1);

  logic [2:0]         state_r, state_nxt;
  idx_t               cnt_r, cnt_nxt;
  logic [NUM_REQ-1:0] pend_r, pend_nxt;
  logic [NUM_REQ-1:0] sched_r, sched_nxt;
  idx_t               start_r, start_nxt;
  logic               await_r, await_nxt;
  idx_t               infl_r, infl_nxt;
  word_t              dtime_r, dtime_nxt;
  word_t              now_r, now_nxt;
  word_t              delay_r, delay_nxt;
  word_t              base_r, max_r;
  out_t               res_r, res_nxt;
  logic               out_valid_r;
  out_t               out_data_r;

  // Retry time and delay stores; entries count only while sched_r is set
  word_t              at_mem [NUM_REQ];
  word_t              dl_mem [NUM_REQ];
  word_t              at_rdata, dl_rdata;
  idx_t               at_raddr;
  logic               at_we, dl_we;
  word_t              at_wdata;

  alu_req_t           alu_req;
  word_t              alu_sum;
  logic               alu_carry;

  idx_t               scan_idx;
  logic               hit;
  word_t              prev;
  logic               out_load;

  rrbs_addsub u_addsub (
    .req   (alu_req),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign scan_idx = start_r + cnt_r;
  assign at_raddr = (state_r == S_IDLE) ? start_r : scan_idx + 1'b1;
  assign hit      = pend_r[scan_idx] || (sched_r[scan_idx] && !alu_sum[WORD_W-1]);
  assign prev     = sched_r[infl_r] ? dl_rdata : '0;
  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    sched_nxt = sched_r;
    start_nxt = start_r;
    await_nxt = await_r;
    infl_nxt  = infl_r;
    dtime_nxt = dtime_r;
    now_nxt   = now_r;
    delay_nxt = delay_r;
    res_nxt   = res_r;
    at_we     = 1'b0;
    dl_we     = 1'b0;
    at_wdata  = alu_sum;
    alu_req   = '{a: now_r, b: at_rdata, sub: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = S_DONE;
          case (in_data.operation)
            OP_RAISE: begin
              if (32'(in_data.request_index) < NUM_REQ) begin
                pend_nxt[in_data.request_index] = 1'b1;
              end
            end
            OP_POLL: begin
              if (in_data.link_up && !await_r) begin
                state_nxt = S_SCAN;
                cnt_nxt   = '0;
                now_nxt   = in_data.now_ms;
              end
            end
            OP_OUTCOME: begin
              if (await_r) begin
                if (in_data.success) begin
                  sched_nxt[infl_r] = 1'b0;
                  await_nxt         = 1'b0;
                end else begin
                  state_nxt = S_GROW;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // Check one entry: fresh pending or retry time reached
        if (hit) begin
          pend_nxt[scan_idx] = 1'b0;
          if (pend_r[scan_idx]) begin
            sched_nxt[scan_idx] = 1'b0;
          end
          start_nxt              = scan_idx + 1'b1;
          await_nxt              = 1'b1;
          infl_nxt               = scan_idx;
          dtime_nxt              = now_r;
          res_nxt.dispatched     = 1'b1;
          res_nxt.dispatch_index = scan_idx;
          state_nxt              = S_DONE;
        end else if (cnt_r == LAST_CNT) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_GROW: begin
        // Compare previous delay against half the cap
        alu_req = '{a: prev, b: {1'b0, max_r[WORD_W-1:1]}, sub: 1'b1};
        if (prev == '0) begin
          delay_nxt = base_r;
        end else if (alu_carry) begin
          delay_nxt = max_r;
        end else begin
          delay_nxt = {prev[WORD_W-2:0], 1'b0};
        end
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // Schedule retry at dispatch time plus delay
        alu_req                    = '{a: dtime_r, b: delay_r, sub: 1'b0};
        at_we                      = 1'b1;
        dl_we                      = 1'b1;
        sched_nxt[infl_r]          = 1'b1;
        await_nxt                  = 1'b0;
        res_nxt.scheduled_delay_ms = delay_r;
        state_nxt                  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= '0;
      sched_r     <= '0;
      start_r     <= '0;
      await_r     <= 1'b0;
      infl_r      <= '0;
      dtime_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      sched_r     <= sched_nxt;
      start_r     <= start_nxt;
      await_r     <= await_nxt;
      infl_r      <= infl_nxt;
      dtime_r     <= dtime_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= WORD_W'(1000);
      max_r  <= WORD_W'(60000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE: base_r <= cfg_data;
        CFG_MAX:  max_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    now_r   <= now_nxt;
    delay_r <= delay_nxt;
    res_r   <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // Retry stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (at_we) begin
      at_mem[infl_r] <= at_wdata;
    end
    at_rdata <= at_mem[at_raddr];
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[infl_r] <= delay_r;
    end
    dl_rdata <= dl_mem[infl_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_scan_idle_link: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !await_r)
    else $error("scan running while a dispatch is outstanding");

  a_hit_awaits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && hit) |=> (await_r && state_r == S_DONE))
    else $error("dispatch did not mark an outstanding outcome");

  a_sum_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> await_r)
    else $error("retry scheduled without an outstanding dispatch");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.dispatched && out_data_r.scheduled_delay_ms != '0))
    else $error("result carries both a dispatch and a retry delay");
`endif

endmodule

// File: dv/tb_round_robin_retry_backoff_scheduler_unit.sv
`timescale 1ns / 1ps

module tb_round_robin_retry_backoff_scheduler_unit;
  import rrbs_pkg::*;

  localparam op_t   OP_SPARE      = 2'd3;  // unused operation code, must be ignored
  localparam word_t RESET_BASE_MS = 32'd1000;
  localparam word_t RESET_MAX_MS  = 32'd60000;
  localparam int    STALL_LIMIT   = 2000;
  localparam int    REPORT_LIMIT  = 10;
  localparam int    PHASE_ITEMS   = 197;
  localparam int    DRAIN_CYCLES  = 12;

  // Track scheduler state and the results owed by accepted transactions
  class sched_scoreboard;
    word_t base_ms;
    word_t cap_ms;
    bit    pending[NUM_REQ];
    bit    armed[NUM_REQ];
    word_t backoff[NUM_REQ];
    word_t retry_at[NUM_REQ];
    int    scan_ptr;
    bit    in_flight;
    idx_t  flight_idx;
    word_t flight_time;
    out_t  owed[$];
    int    mismatches;

    function new();
      base_ms     = RESET_BASE_MS;
      cap_ms      = RESET_MAX_MS;
      scan_ptr    = 0;
      in_flight   = 1'b0;
      flight_idx  = '0;
      flight_time = '0;
      mismatches  = 0;
      for (int k = 0; k < NUM_REQ; k++) begin
        pending[k] = 1'b0;
        clear_entry(k);
      end
    endfunction

    function void set_reg(cfg_idx_t idx, word_t val);
      if (idx == CFG_BASE) base_ms = val;
      else if (idx == CFG_MAX) cap_ms = val;
    endfunction

    function void clear_entry(int k);
      armed[k]    = 1'b0;
      backoff[k]  = '0;
      retry_at[k] = '0;
    endfunction

    // Double the backoff from base, saturating at the cap
    function word_t next_backoff(word_t prev);
      word_t twice;
      if (prev == '0) return base_ms;
      if (prev >= (cap_ms >> 1)) return cap_ms;
      twice = prev << 1;
      return (twice < cap_ms) ? twice : cap_ms;
    endfunction

    function out_t scheduler_step(in_t t);
      out_t  r;
      int    k;
      bit    found;
      word_t since;
      r     = '0;
      found = 1'b0;
      case (t.operation)
        OP_RAISE: begin
          if (int'(t.request_index) < NUM_REQ) pending[t.request_index] = 1'b1;
        end
        OP_POLL: begin
          if (t.link_up && !in_flight) begin
            // Scan round-robin; a fresh raise wins over a due retry at the same slot
            for (int i = 0; i < NUM_REQ && !found; i++) begin
              k     = (scan_ptr + i) % NUM_REQ;
              since = t.now_ms - retry_at[k];
              if (pending[k]) begin
                pending[k] = 1'b0;
                clear_entry(k);
                found = 1'b1;
              end else if (armed[k] && !since[WORD_W-1]) begin
                found = 1'b1;
              end
              if (found) begin
                scan_ptr         = (k + 1) % NUM_REQ;
                in_flight        = 1'b1;
                flight_idx       = idx_t'(k);
                flight_time      = t.now_ms;
                r.dispatched     = 1'b1;
                r.dispatch_index = idx_t'(k);
              end
            end
          end
        end
        OP_OUTCOME: begin
          if (in_flight) begin
            in_flight = 1'b0;
            if (t.success) begin
              clear_entry(flight_idx);
            end else begin
              backoff[flight_idx]  = next_backoff(backoff[flight_idx]);
              retry_at[flight_idx] = flight_time + backoff[flight_idx];
              armed[flight_idx]    = 1'b1;
              r.scheduled_delay_ms = backoff[flight_idx];
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(in_t t);
      owed.push_back(scheduler_step(t));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: dispatched=%0d index=%0d delay=%0d",
                   got.dispatched, got.dispatch_index, got.scheduled_delay_ms);
        return;
      end
      want = owed.pop_front();
      if (got.dispatched !== want.dispatched || got.dispatch_index !== want.dispatch_index ||
          got.scheduled_delay_ms !== want.scheduled_delay_ms) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: expected dispatched=%0d index=%0d delay=%0d, got %0d %0d %0d",
                   want.dispatched, want.dispatch_index, want.scheduled_delay_ms,
                   got.dispatched, got.dispatch_index, got.scheduled_delay_ms);
      end
    endfunction

    function int owed_count();
      return owed.size();
    endfunction

    function void flag_leftovers();
      if (owed.size() != 0) begin
        mismatches += owed.size();
        $display("%0d expected results never arrived", owed.size());
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_t      in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_t     out_data;
  logic     cfg_we    = 1'b0;
  cfg_idx_t cfg_index = CFG_BASE;
  word_t    cfg_data  = '0;

  sched_scoreboard sb;
  bit    idle_on     = 1'b0;
  int    stall_left  = 0;
  int    stuck_cycles = 0;
  int    items_sent  = 0;
  word_t clock_ms    = '0;
  word_t tick_span   = 32'd4000;

  round_robin_retry_backoff_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (!idle_on) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_ready  = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // End the run if no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_item(op_t op, idx_t idx, word_t now, logic link, logic ok);
    in_t t;
    t.operation     = op;
    t.request_index = idx;
    t.now_ms        = now;
    t.link_up       = link;
    t.success       = ok;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = t;
    do @(posedge clk); while (!in_ready);
    sb.note_input(t);
    items_sent++;
  endtask

  // Drop valid and wait until every owed result is back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed_count() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, word_t val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Advance the wall clock, with an occasional jump to any time
  function automatic word_t poll_time();
    if ($urandom_range(0, 19) == 0) return $urandom();
    clock_ms += $urandom_range(0, tick_span);
    return clock_ms;
  endfunction

  // Mostly raise/poll/report flows, with some arbitrary transactions mixed in
  task automatic run_phase(word_t base, word_t cap, word_t span, bit calm);
    int start;
    start = items_sent;
    drain();
    write_reg(CFG_BASE, base);
    write_reg(CFG_MAX, cap);
    tick_span = span;
    idle_on   = !calm;
    while (items_sent - start < PHASE_ITEMS) begin
      if (!calm && $urandom_range(0, 19) == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 3) == 0)
          send_item(OP_RAISE, idx_t'($urandom()), $urandom(), 1'($urandom()),
                    1'($urandom()));
        send_item(OP_POLL, idx_t'($urandom()), poll_time(), $urandom_range(0, 9) != 0,
                  1'($urandom()));
        send_item(OP_OUTCOME, idx_t'($urandom()), $urandom(), 1'($urandom()),
                  $urandom_range(0, 99) < 35);
      end else begin
        send_item(op_t'($urandom_range(0, 3)), idx_t'($urandom()), $urandom(),
                  1'($urandom()), 1'($urandom()));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n   = 1'b1;
    idle_on = 1'b1;

    // Corner cases at reset configuration
    send_item(OP_OUTCOME, 3'd0, 32'd0, 1'b1, 1'b0);         // nothing outstanding
    send_item(OP_POLL, 3'd0, 32'd0, 1'b1, 1'b0);            // nothing ready
    send_item(OP_SPARE, 3'd7, '1, 1'b1, 1'b1);
    send_item(OP_RAISE, 3'd7, '1, 1'b0, 1'b1);
    send_item(OP_RAISE, 3'd0, 32'd0, 1'b1, 1'b0);
    send_item(OP_POLL, 3'd0, 32'd0, 1'b0, 1'b0);            // link down
    send_item(OP_POLL, 3'd0, '1, 1'b1, 1'b0);
    send_item(OP_POLL, 3'd0, '1, 1'b1, 1'b0);               // still awaiting outcome
    send_item(OP_RAISE, 3'd0, 32'd0, 1'b1, 1'b0);           // re-raise while in flight
    send_item(OP_OUTCOME, 3'd0, 32'd0, 1'b1, 1'b0);         // retry time wraps past zero
    send_item(OP_POLL, 3'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    send_item(OP_OUTCOME, 3'd0, 32'd0, 1'b1, 1'b1);
    send_item(OP_POLL, 3'd0, 32'd500, 1'b1, 1'b0);          // fresh raise clears backoff
    send_item(OP_OUTCOME, 3'd0, 32'd0, 1'b1, 1'b0);
    send_item(OP_POLL, 3'd0, 32'd1499, 1'b1, 1'b0);         // one short of due
    send_item(OP_POLL, 3'd0, 32'd1500, 1'b1, 1'b0);         // due exactly
    send_item(OP_OUTCOME, 3'd0, 32'd0, 1'b1, 1'b0);
    send_item(OP_POLL, 3'd0, 32'd3499, 1'b1, 1'b0);
    send_item(OP_POLL, 3'd0, 32'd3500 + 32'h8000_0000, 1'b1, 1'b0);  // reads as the past
    send_item(OP_POLL, 3'd0, 32'd3500 + 32'h7FFF_FFFF, 1'b1, 1'b0);  // farthest still due
    send_item(OP_OUTCOME, 3'd0, 32'd0, 1'b1, 1'b1);

    clock_ms = '0;
    run_phase(RESET_BASE_MS, RESET_MAX_MS, 32'd4000, 1'b0);
    run_phase(32'd1, 32'd1, 32'd3, 1'b0);
    run_phase(32'd3, 32'd7, 32'd12, 1'b0);                  // cap hit at half the cap
    run_phase(32'd5000, 32'd3000, 32'd6000, 1'b0);          // base above cap
    run_phase(32'd1, '1, 32'h3FFF_FFFF, 1'b0);
    run_phase('1, '1, 32'h7FFF_FFFF, 1'b0);
    run_phase(32'd250, 32'd2000, 32'd1500, 1'b1);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.flag_leftovers();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
